// ----- hdl/dtt_pkg.sv -----
// dtt_pkg: shared types, codes and constants for the deadline timer table
// used by dtt_alu and deadline_timer_table_core; no dependencies
package dtt_pkg;

   localparam int TIMER_SLOTS_DEF = 16;
   localparam int MAX_RESULTS     = 15;
   localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

   localparam int TIME_W   = 64;
   localparam int KIND_W   = 2;
   localparam int ID_W     = 4;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int TMO_W    = 22;

   // wait budget cap in microseconds, and the width it needs
   localparam int                NEXT_W   = 31;
   localparam logic [NEXT_W-1:0] WAIT_CAP = 31'h7FFF_FFFF;

   // divide by 1000 as multiply by ceil(2^41 / 1000), exact below 2^31
   localparam int          MS_SHIFT = 41;
   localparam logic [31:0] MS_RECIP = 32'd2199023256;
   localparam int          PROD_W   = NEXT_W + 32;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UNSET = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIRE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TMO   = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd3;

   // shared add/subtract unit
   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   typedef struct packed {
      logic borrow;   // a < b on subtract, carry out on add
      logic zero;     // result is all zero
   } alu_flags_type;

endpackage

// ----- hdl/dtt_alu.sv -----
// dtt_alu: the single 64-bit add/subtract unit shared by every step of the
// timer table sequencer; depends on dtt_pkg
module dtt_alu import dtt_pkg::*; (
   input  logic              op,
   input  logic [TIME_W-1:0] a,
   input  logic [TIME_W-1:0] b,
   output logic [TIME_W-1:0] res,
   output alu_flags_type     flags
);

   logic [TIME_W:0] wide;

   always_comb begin
      if (op == ALU_ADD) begin
         wide = {1'b0, a} + {1'b0, b};
      end else begin
         wide = {1'b0, a} - {1'b0, b};
      end
   end

   assign res          = wide[TIME_W-1:0];
   assign flags.borrow = wide[TIME_W];
   assign flags.zero   = (wide[TIME_W-1:0] == '0);

endmodule

// ----- hdl/deadline_timer_table_core.sv -----
// deadline_timer_table_core: top level of the one-shot deadline timer table
// depends on dtt_pkg and dtt_alu
//
// A table of TIMER_SLOTS one-shot timers kept in a single-port-write,
// registered-read memory of {enable, 64-bit deadline} entries. After reset a
// clearing pass disables every slot in turn; no request is taken meanwhile.
// One request is handled at a time: a small sequencer walks the memory one
// slot per cycle, unless a fired report waits on a full output register, and
// drives one shared 64-bit add/subtract unit. A set walks from slot 1 until
// a free slot, an unset reads its one slot, a fire walks the slots until the
// last one or the MAX_RESULTS-th due timer, and a timeout that is neither
// forced nor out of budget walks the slots until a due timer or the end and,
// if none is due, scales to milliseconds with one registered multiply. Slot
// reads are pipelined, so the memory read port sets the walk at one slot per
// cycle when no report stalls it. Results leave through an output register;
// the final result of every request has tlast set, and a fire reports at
// most MAX_RESULTS timers, leaving later due timers for the next fire.
module deadline_timer_table_core import dtt_pkg::*; #(
   parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
   input  logic          clock,
   input  logic          reset,

   input  logic          req_tvalid,
   output logic          req_tready,
   // now_time[63:0], duration[127:64], timer_id[131:128], start_time[195:132],
   // max_wait[259:196], run_once[260], zero fill[263:261]
   input  logic [263:0]  req_tdata,
   // kind[1:0]
   input  logic [1:0]    req_tuser,

   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[1:0], slot_id[5:2], timeout_ms[27:6], zero fill[31:28]
   output logic [31:0]   rsp_tdata,
   // fired[0]
   output logic          rsp_tuser,
   output logic          rsp_tlast
);

   localparam int IDX_W = $clog2(TIMER_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

   // sequencer states
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_CLEAR    = 4'd0;
   localparam logic [ST_W-1:0] S_IDLE     = 4'd1;
   localparam logic [ST_W-1:0] S_SCAN     = 4'd2;
   localparam logic [ST_W-1:0] S_UNSET_RD = 4'd3;
   localparam logic [ST_W-1:0] S_UNSET_EV = 4'd4;
   localparam logic [ST_W-1:0] S_TMO_CHK  = 4'd5;
   localparam logic [ST_W-1:0] S_DIV      = 4'd6;
   localparam logic [ST_W-1:0] S_DIVOUT   = 4'd7;
   localparam logic [ST_W-1:0] S_EMIT     = 4'd8;

   typedef struct packed {
      logic              en;
      logic [TIME_W-1:0] deadline;
   } slot_entry_type;

   // request fields
   logic [KIND_W-1:0] req_kind;
   logic [TIME_W-1:0] req_now, req_dur, req_start, req_maxw;
   logic [ID_W-1:0]   req_id;
   logic              req_once;

   assign req_kind  = req_tuser;
   assign req_now   = req_tdata[63:0];
   assign req_dur   = req_tdata[127:64];
   assign req_id    = req_tdata[131:128];
   assign req_start = req_tdata[195:132];
   assign req_maxw  = req_tdata[259:196];
   assign req_once  = req_tdata[260];

   // control state
   logic [ST_W-1:0]   state_ff, state_in;
   logic [IDX_W-1:0]  issue_ff, issue_in;        // next slot to read
   logic              issue_on_ff, issue_on_in;  // walk still reading
   logic              ev_valid_ff, ev_valid_in;  // read data is live
   logic [IDX_W-1:0]  ev_idx_ff, ev_idx_in;      // slot of the read data
   logic              pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;  // fired slot held back
   logic [CNT_W-1:0]  hit_cnt_ff, hit_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // latched request
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] dur_ff, dur_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic [TIME_W-1:0] maxw_ff, maxw_in;

   // working values
   logic [NEXT_W-1:0]   next_ff, next_in;       // running minimum gap
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [STATUS_W-1:0] fin_status_ff, fin_status_in;
   logic [SLOT_W-1:0]   fin_slot_ff, fin_slot_in;
   logic                fin_fired_ff, fin_fired_in;
   logic [TMO_W-1:0]    fin_tmo_ff, fin_tmo_in;

   // output register
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                rsp_fired_ff, rsp_fired_in;
   logic [TMO_W-1:0]    rsp_tmo_ff, rsp_tmo_in;
   logic                rsp_last_ff, rsp_last_in;

   // slot memory
   slot_entry_type slot_mem [TIMER_SLOTS];
   slot_entry_type rdata_ff;
   logic           rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic           wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_entry_type wr_data;

   // shared arithmetic unit
   logic              alu_op;
   logic [TIME_W-1:0] alu_a, alu_b, alu_res;
   alu_flags_type     alu_flags;

   logic out_free;   // output register can take a transfer this cycle
   logic due;        // read deadline is at or before now
   logic ev_last;
   logic fire_hit;
   logic stall;      // fired report waits on a full output register
   logic push_pend;
   logic scan_stop;

   dtt_alu u_alu (
      .op    (alu_op),
      .a     (alu_a),
      .b     (alu_b),
      .res   (alu_res),
      .flags (alu_flags)
   );

   // set adds now + duration, every other step subtracts
   always_comb begin
      alu_op = ALU_SUB;
      alu_a  = rdata_ff.deadline;
      alu_b  = now_ff;
      if (state_ff == S_TMO_CHK) begin
         alu_a = now_ff;
         alu_b = start_ff;
      end else if (kind_ff == KIND_SET) begin
         alu_op = ALU_ADD;
         alu_a  = now_ff;
         alu_b  = dur_ff;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign due      = alu_flags.borrow || alu_flags.zero;
   assign ev_last  = (ev_idx_ff == LAST_IDX);
   assign fire_hit = (state_ff == S_SCAN) && ev_valid_ff && (kind_ff == KIND_FIRE)
                     && rdata_ff.en && due;
   assign stall    = fire_hit && pend_valid_ff && !out_free;

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      issue_on_in   = issue_on_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      hit_cnt_in    = hit_cnt_ff;
      kind_in       = kind_ff;
      now_in        = now_ff;
      dur_in        = dur_ff;
      id_in         = id_ff;
      start_in      = start_ff;
      maxw_in       = maxw_ff;
      next_in       = next_ff;
      prod_in       = prod_ff;
      fin_status_in = fin_status_ff;
      fin_slot_in   = fin_slot_ff;
      fin_fired_in  = fin_fired_ff;
      fin_tmo_in    = fin_tmo_ff;
      rd_en         = 1'b0;
      rd_addr       = issue_ff;
      wr_en         = 1'b0;
      wr_addr       = ev_idx_ff;
      wr_data       = '0;
      push_pend     = 1'b0;
      scan_stop     = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            // disable one slot per cycle after reset
            wr_en   = 1'b1;
            wr_addr = issue_ff;
            if (issue_ff == LAST_IDX) begin
               issue_in = '0;
               state_in = S_IDLE;
            end else begin
               issue_in = issue_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               kind_in       = req_kind;
               now_in        = req_now;
               dur_in        = (req_dur == '0) ? TIME_W'(1) : req_dur;
               id_in         = req_id;
               start_in      = req_start;
               maxw_in       = req_maxw;
               pend_valid_in = 1'b0;
               hit_cnt_in    = '0;
               ev_valid_in   = 1'b0;
               fin_status_in = ST_OK;
               fin_slot_in   = '0;
               fin_fired_in  = 1'b0;
               fin_tmo_in    = '0;
               case (req_kind)
                  KIND_SET: begin
                     if (req_dur == '1) begin
                        fin_status_in = ST_INVALID;
                        state_in      = S_EMIT;
                     end else begin
                        // slot 0 is never handed out
                        issue_in    = IDX_W'(1);
                        issue_on_in = 1'b1;
                        state_in    = S_SCAN;
                     end
                  end
                  KIND_UNSET: begin
                     if (req_id == '0 || 32'(req_id) >= TIMER_SLOTS) begin
                        fin_status_in = ST_INVALID;
                        fin_slot_in   = req_id;
                        state_in      = S_EMIT;
                     end else begin
                        state_in = S_UNSET_RD;
                     end
                  end
                  KIND_FIRE: begin
                     issue_in    = '0;
                     issue_on_in = 1'b1;
                     state_in    = S_SCAN;
                  end
                  default: begin
                     if (req_once) begin
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_TMO_CHK;
                     end
                  end
               endcase
            end
         end

         S_UNSET_RD: begin
            rd_en    = 1'b1;
            rd_addr  = IDX_W'(id_ff);
            state_in = S_UNSET_EV;
         end

         S_UNSET_EV: begin
            fin_slot_in = id_ff;
            if (rdata_ff.en) begin
               wr_en         = 1'b1;
               wr_addr       = IDX_W'(id_ff);
               fin_status_in = ST_OK;
            end else begin
               fin_status_in = ST_INACTIVE;
            end
            state_in = S_EMIT;
         end

         S_TMO_CHK: begin
            // budget already spent when now - start >= max_wait
            if (alu_res >= maxw_ff) begin
               state_in = S_EMIT;
            end else begin
               next_in     = (maxw_ff > TIME_W'(WAIT_CAP)) ? WAIT_CAP
                                                           : maxw_ff[NEXT_W-1:0];
               issue_in    = '0;
               issue_on_in = 1'b1;
               state_in    = S_SCAN;
            end
         end

         S_SCAN: begin
            // read side of the walk, one slot per cycle unless a fired report stalls it
            if (!stall) begin
               if (issue_on_ff) begin
                  rd_en       = 1'b1;
                  ev_valid_in = 1'b1;
                  ev_idx_in   = issue_ff;
                  if (issue_ff == LAST_IDX) begin
                     issue_on_in = 1'b0;
                  end else begin
                     issue_in = issue_ff + 1'b1;
                  end
               end else begin
                  ev_valid_in = 1'b0;
               end
            end
            // evaluate side
            if (ev_valid_ff && !stall) begin
               case (kind_ff)
                  KIND_SET: begin
                     if (!rdata_ff.en) begin
                        wr_en            = 1'b1;
                        wr_data.en       = 1'b1;
                        wr_data.deadline = alu_res;
                        fin_status_in    = ST_OK;
                        fin_slot_in      = SLOT_W'(ev_idx_ff);
                        scan_stop        = 1'b1;
                     end else if (ev_last) begin
                        fin_status_in = ST_FULL;
                        scan_stop     = 1'b1;
                     end
                  end
                  KIND_FIRE: begin
                     if (fire_hit) begin
                        wr_en     = 1'b1;
                        push_pend = pend_valid_ff;
                        if (ev_last || hit_cnt_ff == CNT_W'(MAX_RESULTS - 1)) begin
                           fin_fired_in = 1'b1;
                           fin_slot_in  = SLOT_W'(ev_idx_ff);
                           scan_stop    = 1'b1;
                        end else begin
                           pend_valid_in = 1'b1;
                           pend_idx_in   = ev_idx_ff;
                           hit_cnt_in    = hit_cnt_ff + 1'b1;
                        end
                     end else if (ev_last) begin
                        // held-back report becomes the final one
                        fin_fired_in = pend_valid_ff;
                        fin_slot_in  = pend_valid_ff ? SLOT_W'(pend_idx_ff) : '0;
                        scan_stop    = 1'b1;
                     end
                  end
                  default: begin
                     if (rdata_ff.en && due) begin
                        fin_tmo_in = '0;
                        scan_stop  = 1'b1;
                     end else begin
                        if (rdata_ff.en && alu_res < TIME_W'(next_ff)) begin
                           next_in = alu_res[NEXT_W-1:0];
                        end
                        if (ev_last) begin
                           issue_on_in = 1'b0;
                           ev_valid_in = 1'b0;
                           state_in    = S_DIV;
                        end
                     end
                  end
               endcase
            end
            if (scan_stop) begin
               issue_on_in   = 1'b0;
               ev_valid_in   = 1'b0;
               pend_valid_in = 1'b0;
               state_in      = S_EMIT;
            end
         end

         S_DIV: begin
            prod_in  = PROD_W'(next_ff) * PROD_W'(MS_RECIP);
            state_in = S_DIVOUT;
         end

         S_DIVOUT: begin
            fin_tmo_in = prod_ff[MS_SHIFT +: TMO_W];
            state_in   = S_EMIT;
         end

         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: held-back fire reports, then the final result
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_tmo_in    = rsp_tmo_ff;
      rsp_last_in   = rsp_last_ff;
      if (push_pend) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_slot_in   = SLOT_W'(pend_idx_ff);
         rsp_fired_in  = 1'b1;
         rsp_tmo_in    = '0;
         rsp_last_in   = 1'b0;
      end else if (state_ff == S_EMIT && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status_ff;
         rsp_slot_in   = fin_slot_ff;
         rsp_fired_in  = fin_fired_ff;
         rsp_tmo_in    = fin_tmo_ff;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         issue_ff      <= '0;
         issue_on_ff   <= 1'b0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         hit_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         issue_on_ff   <= issue_on_in;
         ev_valid_ff   <= ev_valid_in;
         pend_valid_ff <= pend_valid_in;
         hit_cnt_ff    <= hit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff     <= ev_idx_in;
      pend_idx_ff   <= pend_idx_in;
      kind_ff       <= kind_in;
      now_ff        <= now_in;
      dur_ff        <= dur_in;
      id_ff         <= id_in;
      start_ff      <= start_in;
      maxw_ff       <= maxw_in;
      next_ff       <= next_in;
      prod_ff       <= prod_in;
      fin_status_ff <= fin_status_in;
      fin_slot_ff   <= fin_slot_in;
      fin_fired_ff  <= fin_fired_in;
      fin_tmo_ff    <= fin_tmo_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_tmo_ff    <= rsp_tmo_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_tmo_ff, rsp_slot_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_fired_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // no fired report is left behind when a new request may enter
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_valid_ff)
      else $error("held-back fire report while idle");

   // only a fire report may be a non-final result
   a_nonlast_fired: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> rsp_tuser)
      else $error("non-final result that is not a fire report");

   // the walk only stalls on fire reports
   a_stall_fire: assert property (@(posedge clock) disable iff (reset)
      stall |-> (kind_ff == KIND_FIRE))
      else $error("scan stalled outside a fire request");

   // the slot memory is untouched while idle
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_en)
      else $error("slot memory written while idle");

   // a report push never overlaps a pending output transfer
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push_pend |-> out_free)
      else $error("fire report pushed into a full output register");
`endif

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for deadline_timer_table_core, the one-shot timer table
// depends on dtt_pkg and the core RTL; a directed table runs first, then random requests,
// every result is checked against a timer table kept in the bench
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dtt_pkg::*;

   localparam int NSLOTS          = TIMER_SLOTS_DEF;
   localparam int RANDOM_REQUESTS = 500;
   localparam int LONG_HOLD       = 300;   // cycles the result side stays blocked once
   localparam logic [TIME_W-1:0] ALL_ONES = '1;

   // one request as it travels on the input channel
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TIME_W-1:0] now_us;
      logic [TIME_W-1:0] dur_us;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] start_us;
      logic [TIME_W-1:0] max_wait;
      logic              once;
   } timer_request_type;

   // one result as it leaves the core
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic                fired;
      logic [TMO_W-1:0]    tmo_ms;
      logic                last;
   } timer_result_type;

   // directed row: a request and, where it is obvious, the result typed in by hand
   typedef struct packed {
      timer_request_type req;
      logic              typed;
      timer_result_type  want;
   } plan_row_type;

   logic           clock       = 1'b0;
   logic           reset       = 1'b1;
   logic           req_tvalid  = 1'b0;
   logic           req_tready;
   logic [263:0]   req_tdata;
   logic [1:0]     req_tuser;
   logic           rsp_tvalid;
   logic           rsp_tready  = 1'b0;
   logic [31:0]    rsp_tdata;
   logic           rsp_tuser;
   logic           rsp_tlast;

   timer_request_type req_item = '0;

   // bench copy of the timer table
   logic                armed    [NSLOTS];
   logic [TIME_W-1:0]   deadline [NSLOTS];
   timer_result_type    timer_reports_q [$];
   plan_row_type        directed_plan [$];

   logic [TIME_W-1:0]   sim_now       = '0;
   bit                  hold_off_req  = 1'b0;
   int                  n_errors      = 0;
   int                  n_requests    = 0;
   int                  n_results     = 0;
   int                  n_expired     = 0;
   int                  n_full        = 0;
   int                  n_kind [4]    = '{0, 0, 0, 0};

   // now_time, duration, timer_id, start_time, max_wait, run_once, zero fill
   assign req_tdata = {3'b000, req_item.once, req_item.max_wait, req_item.start_us,
                       req_item.id, req_item.dur_us, req_item.now_us};
   assign req_tuser = req_item.kind;

   deadline_timer_table_core #(.TIMER_SLOTS(NSLOTS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   // microseconds left to wait: zero when forced, budget spent or a timer already due
   function automatic logic [TIME_W-1:0] wait_left_us(input timer_request_type rq);
      logic [TIME_W-1:0] best;
      if (rq.once)
         return '0;
      if (rq.now_us - rq.start_us >= rq.max_wait)
         return '0;
      // large budgets are clipped before the minimum is taken
      best = (rq.max_wait > {33'd0, WAIT_CAP}) ? {33'd0, WAIT_CAP} : rq.max_wait;
      for (int i = 0; i < NSLOTS; i++) begin
         if (armed[i]) begin
            if (deadline[i] <= rq.now_us)
               return '0;
            if (deadline[i] - rq.now_us < best)
               best = deadline[i] - rq.now_us;
         end
      end
      return best;
   endfunction

   // apply one request to the bench table and queue the results it causes
   task automatic advance_timer_table(input timer_request_type rq);
      timer_result_type  r;
      timer_result_type  held;
      logic [TIME_W-1:0] dur;
      logic [TIME_W-1:0] ms;
      int                n;
      r      = '0;
      r.last = 1'b1;
      case (rq.kind)
         KIND_SET: begin
            if (rq.dur_us == ALL_ONES) begin
               r.status = ST_INVALID;
            end else begin
               // zero delay still means the next tick
               dur      = (rq.dur_us == '0) ? 64'd1 : rq.dur_us;
               r.status = ST_FULL;
               // slot 0 is never handed out
               for (int i = 1; i < NSLOTS; i++) begin
                  if (!armed[i]) begin
                     armed[i]    = 1'b1;
                     deadline[i] = rq.now_us + dur;
                     r.status    = ST_OK;
                     r.slot      = SLOT_W'(i);
                     break;
                  end
               end
            end
            timer_reports_q.push_back(r);
         end
         KIND_UNSET: begin
            r.slot = rq.id;
            if (rq.id == '0 || int'(rq.id) >= NSLOTS)
               r.status = ST_INVALID;
            else if (!armed[rq.id])
               r.status = ST_INACTIVE;
            else
               armed[rq.id] = 1'b0;
            timer_reports_q.push_back(r);
         end
         KIND_FIRE: begin
            // one result per due timer in slot order, at most MAX_RESULTS, tlast on the final one
            n    = 0;
            held = '0;
            for (int i = 0; i < NSLOTS && n < MAX_RESULTS; i++) begin
               if (armed[i] && rq.now_us >= deadline[i]) begin
                  armed[i] = 1'b0;
                  if (n > 0)
                     timer_reports_q.push_back(held);
                  held       = '0;
                  held.slot  = SLOT_W'(i);
                  held.fired = 1'b1;
                  n++;
               end
            end
            if (n == 0) begin
               timer_reports_q.push_back(r);
            end else begin
               held.last = 1'b1;
               timer_reports_q.push_back(held);
            end
         end
         default: begin
            ms       = wait_left_us(rq) / 64'd1000;
            r.tmo_ms = ms[TMO_W-1:0];
            timer_reports_q.push_back(r);
         end
      endcase
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t ns, result %0d: %s is %0h, expected %0h",
               $time, n_results, field, got, want);
      n_errors++;
   endtask

   task automatic check_report();
      timer_result_type got;
      timer_result_type want;
      got = {rsp_tdata[1:0], rsp_tdata[5:2], rsp_tuser, rsp_tdata[27:6], rsp_tlast};
      n_results++;
      if (got.fired === 1'b1)
         n_expired++;
      if (got.status === ST_FULL)
         n_full++;
      if (timer_reports_q.size() == 0) begin
         report_mismatch("unexpected result", 64'(got), '0);
      end else begin
         want = timer_reports_q.pop_front();
         if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
         if (got.slot !== want.slot)
            report_mismatch("slot_id", 64'(got.slot), 64'(want.slot));
         if (got.fired !== want.fired)
            report_mismatch("fired", 64'(got.fired), 64'(want.fired));
         if (got.tmo_ms !== want.tmo_ms)
            report_mismatch("timeout_ms", 64'(got.tmo_ms), 64'(want.tmo_ms));
         if (got.last !== want.last)
            report_mismatch("last", 64'(got.last), 64'(want.last));
      end
   endtask

   // decode an accepted request from the pins and predict its results
   task automatic take_request();
      timer_request_type rq;
      plan_row_type      row;
      rq.kind     = req_tuser;
      rq.now_us   = req_tdata[63:0];
      rq.dur_us   = req_tdata[127:64];
      rq.id       = req_tdata[131:128];
      rq.start_us = req_tdata[195:132];
      rq.max_wait = req_tdata[259:196];
      rq.once     = req_tdata[260];
      n_kind[rq.kind]++;
      advance_timer_table(rq);
      // hand-typed rows replace the predicted result, the table update stays
      if (n_requests < directed_plan.size()) begin
         row = directed_plan[n_requests];
         if (row.typed) begin
            void'(timer_reports_q.pop_back());
            timer_reports_q.push_back(row.want);
         end
      end
      n_requests++;
   endtask

   // both channels sampled at the rising edge, before the core updates
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            check_report();
         if (req_tvalid && req_tready)
            take_request();
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic add_step(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now_us,
                           input logic [TIME_W-1:0] dur_us, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] start_us, input logic [TIME_W-1:0] budget,
                           input logic once, input logic typed,
                           input logic [STATUS_W-1:0] st, input logic [SLOT_W-1:0] slot,
                           input logic [TMO_W-1:0] tmo);
      plan_row_type row;
      row.req           = {kind, now_us, dur_us, id, start_us, budget, once};
      row.typed         = typed;
      row.want          = '0;
      row.want.status   = st;
      row.want.slot     = slot;
      row.want.tmo_ms   = tmo;
      row.want.last     = 1'b1;
      directed_plan.push_back(row);
   endtask

   // mostly well-formed traffic on a clock that moves forward, with rare jumps
   function automatic timer_request_type random_request();
      timer_request_type rq;
      int                pick;
      pick    = $urandom_range(0, 99);
      rq.kind = (pick < 35) ? KIND_SET : (pick < 55) ? KIND_UNSET :
                (pick < 78) ? KIND_FIRE : KIND_TMO;
      case ($urandom_range(0, 39))
         0:       sim_now = {$urandom, $urandom};
         1:       sim_now = ALL_ONES - 64'($urandom_range(0, 4000));
         default: sim_now = sim_now + 64'($urandom_range(0, 3000));
      endcase
      rq.now_us = sim_now;
      case ($urandom_range(0, 19))
         0:       rq.dur_us = '0;
         1:       rq.dur_us = ALL_ONES;
         2:       rq.dur_us = ALL_ONES - 64'd1;
         3:       rq.dur_us = {$urandom, $urandom};
         default: rq.dur_us = 64'($urandom_range(1, 8000));
      endcase
      rq.id = ($urandom_range(0, 11) == 0) ? '0 : ID_W'($urandom_range(1, NSLOTS - 1));
      rq.start_us = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                                : sim_now - 64'($urandom_range(0, 20000));
      case ($urandom_range(0, 9))
         0:       rq.max_wait = ALL_ONES;
         1:       rq.max_wait = {$urandom, $urandom};
         2:       rq.max_wait = '0;
         3:       rq.max_wait = {32'd0, $urandom};
         default: rq.max_wait = 64'($urandom_range(0, 30_000_000));
      endcase
      rq.once = ($urandom_range(0, 7) == 0);
      return rq;
   endfunction

   // gap before a request; every hundred requests starts with a run of back-to-back ones
   function automatic int pace(input int n);
      return ((n % 100) < 20) ? 0 : int'($urandom_range(0, 11));
   endfunction

   // entered and left at a falling edge
   task automatic offer(input timer_request_type rq, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item   <= rq;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   initial begin
      timer_request_type rq;
      for (int i = 0; i < NSLOTS; i++)
         armed[i] = 1'b0;

      //       kind        now            duration       id     start  budget    once
      //       typed  status       slot   timeout_ms
      // forced zero wait, then the largest wait on an empty table
      add_step(KIND_TMO,   64'd0,         64'd0,         4'd0,  64'd0, ALL_ONES, 1'b1,
               1'b1,  ST_OK,       4'd0,  22'd0);
      add_step(KIND_TMO,   64'd5,         64'd0,         4'd0,  64'd0, ALL_ONES, 1'b0,
               1'b1,  ST_OK,       4'd0,  22'd2147483);
      // fire with nothing armed gives one empty result
      add_step(KIND_FIRE,  64'd0,         64'd0,         4'd0,  64'd0, 64'd0,    1'b0,
               1'b1,  ST_OK,       4'd0,  22'd0);
      // unset of slot 0 is refused, unset of an idle slot reports it
      add_step(KIND_UNSET, 64'd0,         64'd0,         4'd0,  64'd0, 64'd0,    1'b0,
               1'b1,  ST_INVALID,  4'd0,  22'd0);
      add_step(KIND_UNSET, 64'd0,         64'd0,         4'd15, 64'd0, 64'd0,    1'b0,
               1'b1,  ST_INACTIVE, 4'd15, 22'd0);
      // all-ones duration is refused
      add_step(KIND_SET,   64'd0,         ALL_ONES,      4'd0,  64'd0, 64'd0,    1'b0,
               1'b1,  ST_INVALID,  4'd0,  22'd0);
      // zero delay, a deadline that wraps past 2^64, a deadline far away
      add_step(KIND_SET,   64'd100,       64'd0,         4'd0,  64'd0, 64'd0,    1'b0,
               1'b1,  ST_OK,       4'd1,  22'd0);
      add_step(KIND_SET,   ALL_ONES - 64'd15, 64'd32,    4'd0,  64'd0, 64'd0,    1'b0,
               1'b1,  ST_OK,       4'd2,  22'd0);
      add_step(KIND_SET,   64'd0,         ALL_ONES - 64'd1, 4'd0, 64'd0, 64'd0,  1'b0,
               1'b1,  ST_OK,       4'd3,  22'd0);
      // a timer already due, then a spent budget
      add_step(KIND_TMO,   64'd50,        64'd0,         4'd0,  64'd0, 64'd1000000, 1'b0,
               1'b0,  ST_OK,       4'd0,  22'd0);
      add_step(KIND_TMO,   64'd1000,      64'd0,         4'd0,  64'd0, 64'd1000, 1'b0,
               1'b1,  ST_OK,       4'd0,  22'd0);
      // only the wrapped deadline has passed
      add_step(KIND_FIRE,  64'd100,       64'd0,         4'd0,  64'd0, 64'd0,    1'b0,
               1'b0,  ST_OK,       4'd0,  22'd0);
      // fill every free slot, then one set too many
      for (int k = 0; k < NSLOTS - 3; k++)
         add_step(KIND_SET, 64'd1000 + 64'(10 * k), 64'd500 + 64'(997 * k), 4'd0,
                  64'd0, 64'd0, 1'b0, 1'b0, ST_OK, 4'd0, 22'd0);
      add_step(KIND_SET,   64'd0,         64'd5,         4'd0,  64'd0, 64'd0,    1'b0,
               1'b1,  ST_FULL,     4'd0,  22'd0);
      add_step(KIND_UNSET, 64'd0,         64'd0,         4'd7,  64'd0, 64'd0,    1'b0,
               1'b1,  ST_OK,       4'd7,  22'd0);
      // at the end of time every armed timer fires in one burst
      add_step(KIND_FIRE,  ALL_ONES,      64'd0,         4'd0,  64'd0, 64'd0,    1'b0,
               1'b0,  ST_OK,       4'd0,  22'd0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < directed_plan.size(); k++) begin
         rq = directed_plan[k].req;
         offer(rq, pace(k));
      end
      for (int k = 0; k < RANDOM_REQUESTS; k++) begin
         // ask the result side to block for a long stretch while requests keep coming
         if (k == 150)
            hold_off_req = 1'b1;
         rq = random_request();
         offer(rq, pace(k + directed_plan.size()));
      end
      req_tvalid <= 1'b0;

      // drain, then allow the longest walk of the table for stray results
      while (timer_reports_q.size() != 0)
         @(posedge clock);
      repeat (3 * NSLOTS) @(posedge clock);

      $display("ran %0d requests: %0d set, %0d unset, %0d fire, %0d timeout query",
               n_requests, n_kind[KIND_SET], n_kind[KIND_UNSET], n_kind[KIND_FIRE],
               n_kind[KIND_TMO]);
      $display("%0d results seen, %0d expirations, %0d sets refused on a full table",
               n_results, n_expired, n_full);
      $display("%0d mismatches", n_errors);
      if (n_errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // result side: random stall before each transfer, with runs of no stall
   initial begin
      int stall;
      int taken;
      taken = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_off_req = 1'b0;
         end
         stall = ((taken % 64) < 16) ? 0 : int'($urandom_range(0, 11));
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         @(negedge clock);
      end
   end

   // run limit, well beyond the slowest legal run
   initial begin
      #(20_000_000);
      $display("timeout at %0t ns with %0d results outstanding", $time, timer_reports_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
